// File: hw/rtl/ggs_pkg.sv
`timescale 1ns / 1ps
// go-to-goal steering package: payload structs, stage records, register indexes
// and the cordic arctangent table; no dependencies
package ggs_pkg;

    localparam int CORDIC_STAGES = 16;  // range 8 to 24
    localparam int TABLE_LEN     = 24;

    localparam logic [3:0] CFG_POSITION_MARGIN = 4'd0;
    localparam logic [3:0] CFG_HEADING_MARGIN  = 4'd1;
    localparam logic [3:0] CFG_BASE_SPEED      = 4'd2;
    localparam logic [3:0] CFG_TURN_RATE       = 4'd3;

    localparam logic [15:0] RST_POSITION_MARGIN = 16'd410;
    localparam logic [14:0] RST_HEADING_MARGIN  = 15'd1043;
    localparam logic [15:0] RST_BASE_SPEED      = 16'd819;
    localparam logic [14:0] RST_TURN_RATE       = 15'd410;

    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0] BEARING_RND = 32'h0000_8000;
    localparam logic [31:0] INV_GAIN   = 32'd2608131496;
    localparam logic [63:0] DIST_RND   = 64'h0000_0008_0000_0000;
    localparam logic [27:0] ONE_METRE  = 28'd4096;
    localparam logic [23:0] SPEED_MAX  = 24'hFF_FFFF;
    localparam logic [15:0] ERR_HALF   = 16'h8000;

    typedef struct packed {
        logic signed [23:0] robot_x;
        logic signed [23:0] robot_y;
        logic signed [15:0] robot_heading;
        logic signed [23:0] goal_x;
        logic signed [23:0] goal_y;
    } ggs_in_t;

    typedef struct packed {
        logic [23:0]        forward_speed;
        logic signed [15:0] turn_speed;
        logic               arrived;
    } ggs_out_t;

    typedef struct packed {
        logic [15:0] position_margin;
        logic [14:0] heading_margin;
        logic [15:0] base_speed;
        logic [14:0] turn_rate;
    } cfg_t;

    typedef struct packed {
        logic        arrived;
        logic        zero;
        logic [15:0] heading;
    } side_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        z;
        side_t              side;
    } vec_t;

    function automatic logic [31:0] atan_units(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/ggs_prep.sv
`timescale 1ns / 1ps
// front end: goal offsets, arrival test and cordic pre-rotation, two stages
// depends on ggs_pkg
module ggs_prep (
    input  logic            aclk,
    input  logic            aresetn,
    input  ggs_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  ggs_pkg::ggs_in_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ggs_pkg::vec_t   out_data
);

    logic signed [24:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [15:0]        head_reg;
    logic               va_reg, vb_reg;
    logic               rdy_a, rdy_b;
    ggs_pkg::vec_t      vec_reg, vec_next;
    logic [24:0]        adx, ady, ax, ay;
    logic               neg;

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    assign dx_next = {in_data.goal_x[23], in_data.goal_x} - {in_data.robot_x[23], in_data.robot_x};
    assign dy_next = {in_data.goal_y[23], in_data.goal_y} - {in_data.robot_y[23], in_data.robot_y};

    always_comb begin
        adx = dx_reg[24] ? 25'(-dx_reg) : dx_reg;
        ady = dy_reg[24] ? 25'(-dy_reg) : dy_reg;
        neg = dx_reg[24];
        // left half plane: rotate by a half turn first
        ax  = neg ? 25'(-dx_reg) : dx_reg;
        ay  = neg ? 25'(-dy_reg) : dy_reg;
        vec_next.x = {{3{ax[24]}}, ax, 4'b0};
        vec_next.y = {{3{ay[24]}}, ay, 4'b0};
        vec_next.z = neg ? ggs_pkg::HALF_TURN : 32'h0;
        vec_next.side.arrived = (adx < {9'b0, cfg.position_margin}) &&
                                (ady < {9'b0, cfg.position_margin});
        vec_next.side.zero    = (dx_reg == 25'sd0) && (dy_reg == 25'sd0);
        vec_next.side.heading = head_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                va_reg <= in_valid;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
        end
        if (rdy_a && in_valid) begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            head_reg <= in_data.robot_heading;
        end
        if (rdy_b && va_reg) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = vec_reg;

endmodule

// File: hw/rtl/ggs_cordic.sv
`timescale 1ns / 1ps
// vectoring cordic, one register stage per micro-rotation
// depends on ggs_pkg
module ggs_cordic (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ggs_pkg::vec_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ggs_pkg::vec_t out_data
);

    localparam int N = ggs_pkg::CORDIC_STAGES;

    ggs_pkg::vec_t stage_in  [N+1];
    logic          valid_in  [N+1];
    logic          rdy       [N+1];
    ggs_pkg::vec_t stage_reg [N];
    logic          v_reg     [N];

    assign stage_in[0] = in_data;
    assign valid_in[0] = in_valid;
    assign rdy[N]      = out_ready;
    assign in_ready    = rdy[0];

    for (genvar k = 0; k < N; k++) begin : g_stage
        ggs_pkg::vec_t      nxt;
        logic signed [31:0] xs, ys;
        logic               up;
        logic [31:0]        a;

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb begin
            xs  = stage_in[k].x >>> k;
            ys  = stage_in[k].y >>> k;
            up  = !stage_in[k].y[31] && (stage_in[k].y != 32'sd0);
            a   = ggs_pkg::atan_units(5'(k));
            nxt = stage_in[k];
            if (up) begin
                nxt.x = stage_in[k].x + ys;
                nxt.y = stage_in[k].y - xs;
                nxt.z = stage_in[k].z + a;
            end else begin
                nxt.x = stage_in[k].x - ys;
                nxt.y = stage_in[k].y + xs;
                nxt.z = stage_in[k].z - a;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= valid_in[k];
            end
            if (rdy[k] && valid_in[k]) begin
                stage_reg[k] <= nxt;
            end
        end

        assign stage_in[k+1] = stage_reg[k];
        assign valid_in[k+1] = v_reg[k];
    end

    assign out_valid = valid_in[N];
    assign out_data  = stage_in[N];

endmodule

// File: hw/rtl/ggs_post.sv
`timescale 1ns / 1ps
// back end: heading error, gain correction, speed product and output select
// depends on ggs_pkg; its last stage is the block's output register
module ggs_post (
    input  logic              aclk,
    input  logic              aresetn,
    input  ggs_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  ggs_pkg::vec_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ggs_pkg::ggs_out_t out_data
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        rdy1, rdy2, rdy3;
    logic [62:0] prod_reg, prod_next;
    logic        arr1_reg, str1_reg, left1_reg;
    logic        arr2_reg, str2_reg, left2_reg;
    logic [43:0] sp_reg, sp_next;
    ggs_pkg::ggs_out_t out_reg, out_next;
    logic [31:0] zr;
    logic [15:0] bearing, err, aerr;
    logic        left, straight;
    logic [30:0] xpos;
    logic [63:0] rsum;
    logic [27:0] span, dmax;
    logic [31:0] v;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        zr       = in_data.z + ggs_pkg::BEARING_RND;
        bearing  = in_data.side.zero ? 16'h0 : zr[31:16];
        err      = bearing - in_data.side.heading;
        aerr     = err[15] ? 16'(-err) : err;
        // a half turn error counts as +pi: turn left, never straight
        left     = (err == ggs_pkg::ERR_HALF) || (!err[15] && (err != 16'h0));
        straight = (err != ggs_pkg::ERR_HALF) && (aerr < {1'b0, cfg.heading_margin});
        xpos     = (in_data.x[31] || in_data.side.zero) ? 31'h0 : in_data.x[30:0];
        prod_next = {32'h0, xpos} * {31'h0, ggs_pkg::INV_GAIN};
    end

    always_comb begin
        rsum    = {1'b0, prod_reg} + ggs_pkg::DIST_RND;
        span    = rsum[63:36];
        dmax    = (span > ggs_pkg::ONE_METRE) ? span : ggs_pkg::ONE_METRE;
        sp_next = {28'h0, cfg.base_speed} * {16'h0, dmax};
    end

    always_comb begin
        v        = sp_reg[43:12];
        out_next = '0;
        if (arr2_reg) begin
            out_next.arrived = 1'b1;
        end else if (str2_reg) begin
            out_next.forward_speed = (v[31:24] != 8'h0) ? ggs_pkg::SPEED_MAX : v[23:0];
        end else begin
            out_next.turn_speed = left2_reg ? {1'b0, cfg.turn_rate}
                                            : 16'(16'h0 - {1'b0, cfg.turn_rate});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
        if (rdy1 && in_valid) begin
            prod_reg  <= prod_next;
            arr1_reg  <= in_data.side.arrived;
            str1_reg  <= straight;
            left1_reg <= left;
        end
        if (rdy2 && v1_reg) begin
            sp_reg    <= sp_next;
            arr2_reg  <= arr1_reg;
            str2_reg  <= str1_reg;
            left2_reg <= left1_reg;
        end
        if (rdy3 && v2_reg) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

// File: hw/rtl/go_to_goal_steering_unit.sv
`timescale 1ns / 1ps
// top level of the go-to-goal steering unit: config registers and pipeline
// depends on ggs_pkg, ggs_prep, ggs_cordic, ggs_post
//
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     s_data   (ggs_in_t)
//  m_        out        m_valid / m_ready     m_data   (ggs_out_t)
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one transaction per cycle while m_ready does not stall the pipeline; the stages are
// two front-end stages, one per cordic micro-rotation and three back-end stages
// synchronous active-low reset clears valid bits and loads register defaults
// each stage holds while its successor is full and stalled, so a stall on m_
// backs up stage by stage and bubbles are squeezed out
// cfg_ready is always high; writes to unknown indexes are dropped
module go_to_goal_steering_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ggs_pkg::ggs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ggs_pkg::ggs_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    ggs_pkg::cfg_t cfg_reg;

    // front end to cordic
    logic          pc_valid, pc_ready;
    ggs_pkg::vec_t pc_data;
    // cordic to back end
    logic          cp_valid, cp_ready;
    ggs_pkg::vec_t cp_data;

    assign cfg_ready = 1'b1;

    // register file, values masked to register width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.position_margin <= ggs_pkg::RST_POSITION_MARGIN;
            cfg_reg.heading_margin  <= ggs_pkg::RST_HEADING_MARGIN;
            cfg_reg.base_speed      <= ggs_pkg::RST_BASE_SPEED;
            cfg_reg.turn_rate       <= ggs_pkg::RST_TURN_RATE;
        end else if (cfg_valid) begin
            case (cfg_index)
                ggs_pkg::CFG_POSITION_MARGIN: cfg_reg.position_margin <= cfg_data;
                ggs_pkg::CFG_HEADING_MARGIN:  cfg_reg.heading_margin  <= cfg_data[14:0];
                ggs_pkg::CFG_BASE_SPEED:      cfg_reg.base_speed      <= cfg_data;
                ggs_pkg::CFG_TURN_RATE:       cfg_reg.turn_rate       <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // offsets, arrival test, half-plane fold
    ggs_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (pc_valid),
        .out_ready (pc_ready),
        .out_data  (pc_data)
    );

    // bearing and unscaled magnitude
    ggs_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pc_valid),
        .in_ready  (pc_ready),
        .in_data   (pc_data),
        .out_valid (cp_valid),
        .out_ready (cp_ready),
        .out_data  (cp_data)
    );

    // heading error, speed and command select
    ggs_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (cp_valid),
        .in_ready  (cp_ready),
        .in_data   (cp_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // arrival always comes with both speeds at zero
    a_arrived_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.arrived |-> m_data.forward_speed == 24'h0 &&
                                      m_data.turn_speed == 16'sh0)
        else $error("arrival with nonzero speed");

    // never drive and turn at once
    a_one_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.forward_speed != 24'h0 |-> m_data.turn_speed == 16'sh0)
        else $error("forward and turn speed both set");

    // a turn command always has the configured magnitude
    a_turn_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.turn_speed != 16'sh0 |->
            m_data.turn_speed == $signed({1'b0, cfg_reg.turn_rate}) ||
            m_data.turn_speed == $signed(16'h0 - {1'b0, cfg_reg.turn_rate}))
        else $error("turn speed magnitude mismatch");

    // with the sink ready the whole pipeline flows
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output ready");

endmodule
